// ===== src/dtbm_pkg.sv =====
// Shared types and constants for the direction table best-match block.
// No dependencies; the interfaces and the top level import it.
package dtbm_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_DOT_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENTRY_COUNT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROTATE_ENABLE = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [5:0]         entry_index;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
    logic               use_rotation;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } item_t;

  typedef struct packed {
    logic       matched;
    logic [5:0] best_index;
  } result_t;

endpackage

// ===== src/dtbm_if.sv =====
// Valid/ready channel interfaces of the direction table best-match block.
// Depends on dtbm_pkg for the payload types.
interface dtbm_item_if;
  import dtbm_pkg::*;
  logic  valid;
  logic  ready;
  item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface dtbm_result_if;
  import dtbm_pkg::*;
  logic    valid;
  logic    ready;
  result_t result;
  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

interface dtbm_cfg_if;
  import dtbm_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/direction_table_best_match.sv =====
// Top level of the direction table best-match block: table memory, sequencer
// and one shared multiplier. Depends on dtbm_pkg and the interfaces in dtbm_if.
//
// One transaction at a time. A load normalizes its vector and writes the table:
// squares, a bit-serial square root, restoring division of each component and
// dispatch (a zero vector skips the root and the division). A query takes the
// same normalization, then the quaternion rotation when it is applied, then walks
// each table entry in use (one memory read, three multiply-accumulates on the
// shared 17x34 multiplier) before it writes the result. The block takes a new
// transaction while a finished result still waits in the output register.
module direction_table_best_match #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dtbm_item_if.sink     item_i,
  dtbm_result_if.source result_o,
  dtbm_cfg_if.sink      cfg_i
);
  import dtbm_pkg::*;

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SQRT = 4'd2;
  localparam logic [3:0] S_DIVI = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_NEXT = 4'd5;
  localparam logic [3:0] S_ROT  = 4'd6;
  localparam logic [3:0] S_WALK = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_DOT  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  function automatic logic [1:0] nxt1(input logic [1:0] j);
    logic [1:0] r;
    unique case (j)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nxt2(input logic [1:0] j);
    logic [1:0] r;
    unique case (j)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat_sign(input logic neg, input logic [23:0] n);
    logic [15:0] nn;
    nn = (n > 24'd16384) ? 16'd16384 : n[15:0];
    return neg ? 16'(-nn) : nn;
  endfunction

  function automatic logic [48:0] div_num(input logic signed [15:0] c,
                                          input logic [31:0] len);
    logic signed [16:0] ce;
    logic [16:0]        m;
    ce = 17'(c);
    m  = ce[16] ? 17'(-ce) : 17'(ce);
    return (49'(m) << 28) + 49'(len >> 1);
  endfunction

  function automatic logic signed [15:0] round_q42(input logic signed [51:0] a);
    logic [51:0] m;
    logic [23:0] n;
    m = a[51] ? 52'(-a) : 52'(a);
    n = 24'((m + 52'd134217728) >> 28);
    return sat_sign(a[51], n);
  endfunction

  // configuration
  logic signed [15:0] thr_q;
  logic [6:0]         ecount_q;
  logic               rot_en_q;

  // control
  logic [3:0]      state_q, state_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [1:0]      comp_q, comp_d;
  logic            ph_q, ph_d;
  logic [CntW-1:0] widx_q, widx_d;
  logic [CntW-1:0] lim_q, lim_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] bidx_q, bidx_d;
  logic            outv_q, outv_d;
  result_t         res_q, res_d;

  // datapath
  logic               kind_q, kind_d;
  logic [5:0]         eidx_q, eidx_d;
  logic               rot_q, rot_d;
  logic signed [15:0] vec_q [3];
  logic signed [15:0] vec_d [3];
  logic signed [15:0] quat_q [4];
  logic signed [15:0] quat_d [4];
  logic signed [15:0] dir_q [3];
  logic signed [15:0] dir_d [3];
  logic signed [33:0] t_q [3];
  logic signed [33:0] t_d [3];
  logic signed [51:0] acc_q, acc_d;
  logic signed [51:0] best_q, best_d;
  logic [62:0]        v_q, v_d, r_q, r_d, b_q, b_d;
  logic [31:0]        len_q, len_d;
  logic [48:0]        rem_q, rem_d;
  logic [16:0]        quo_q, quo_d;
  logic [47:0]        rd_q;
  logic [47:0]        mem_q [MAX_ENTRIES];

  logic signed [16:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [50:0] prod;
  logic signed [16:0] u [3];

  assign prod = mul_a * mul_b;
  assign u[0] = -17'(quat_q[0]);
  assign u[1] = -17'(quat_q[1]);
  assign u[2] = -17'(quat_q[2]);

  assign item_i.ready    = (state_q == S_IDLE);
  assign result_o.valid  = outv_q;
  assign result_o.result = res_q;
  assign cfg_i.ready     = 1'b1;

  always_comb begin
    logic signed [51:0] sum;
    logic [62:0]        rb;
    logic [62:0]        r_nx;
    logic [48:0]        dsh;
    logic [16:0]        q_nx;
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    ph_d    = ph_q;
    widx_d  = widx_q;
    lim_d   = lim_q;
    found_d = found_q;
    bidx_d  = bidx_q;
    outv_d  = outv_q;
    res_d   = res_q;
    kind_d  = kind_q;
    eidx_d  = eidx_q;
    rot_d   = rot_q;
    vec_d   = vec_q;
    quat_d  = quat_q;
    dir_d   = dir_q;
    t_d     = t_q;
    acc_d   = acc_q;
    best_d  = best_q;
    v_d     = v_q;
    r_d     = r_q;
    b_d     = b_q;
    len_d   = len_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    mul_a   = '0;
    mul_b   = '0;
    sum     = '0;
    rb      = '0;
    r_nx    = '0;
    dsh     = '0;
    q_nx    = '0;

    if (outv_q && result_o.ready) begin
      outv_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (item_i.valid) begin
          kind_d    = item_i.item.kind;
          eidx_d    = item_i.item.entry_index;
          rot_d     = item_i.item.use_rotation & rot_en_q;
          vec_d[0]  = item_i.item.vec_x;
          vec_d[1]  = item_i.item.vec_y;
          vec_d[2]  = item_i.item.vec_z;
          quat_d[0] = item_i.item.quat_x;
          quat_d[1] = item_i.item.quat_y;
          quat_d[2] = item_i.item.quat_z;
          quat_d[3] = item_i.item.quat_w;
          acc_d     = '0;
          comp_d    = 2'd0;
          state_d   = S_SQ;
        end
      end
      S_SQ: begin
        mul_a = 17'(vec_q[comp_q]);
        mul_b = 34'(vec_q[comp_q]);
        sum   = acc_q + 52'(prod);
        acc_d = sum;
        if (comp_q == 2'd2) begin
          if (sum == '0) begin
            dir_d[0] = '0;
            dir_d[1] = '0;
            dir_d[2] = '0;
            state_d  = S_NEXT;
          end else begin
            v_d     = 63'($unsigned(sum)) << 28;
            r_d     = '0;
            b_d     = 63'(1) << 62;
            cnt_d   = 5'd31;
            state_d = S_SQRT;
          end
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      S_SQRT: begin
        rb = r_q + b_q;
        if (v_q >= rb) begin
          v_d  = v_q - rb;
          r_nx = (r_q >> 1) + b_q;
        end else begin
          r_nx = r_q >> 1;
        end
        r_d = r_nx;
        b_d = b_q >> 2;
        if (cnt_q == 5'd0) begin
          len_d   = r_nx[31:0];
          state_d = S_DIVI;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_DIVI: begin
        rem_d   = div_num(vec_q[0], len_q);
        quo_d   = '0;
        cnt_d   = 5'd16;
        comp_d  = 2'd0;
        state_d = S_DIV;
      end
      S_DIV: begin
        dsh  = 49'(len_q) << cnt_q;
        q_nx = quo_q;
        if (rem_q >= dsh) begin
          rem_d = rem_q - dsh;
          q_nx  = quo_q | (17'(1) << cnt_q);
        end
        quo_d = q_nx;
        if (cnt_q == 5'd0) begin
          dir_d[comp_q] = sat_sign(vec_q[comp_q][15], 24'(q_nx));
          if (comp_q == 2'd2) begin
            state_d = S_NEXT;
          end else begin
            comp_d = comp_q + 2'd1;
            cnt_d  = 5'd16;
            quo_d  = '0;
            rem_d  = div_num(vec_q[comp_q + 2'd1], len_q);
          end
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_NEXT: begin
        if (kind_q == KIND_LOAD) begin
          state_d = S_IDLE;
        end else if (rot_q) begin
          comp_d  = 2'd0;
          cnt_d   = 5'd0;
          ph_d    = 1'b0;
          state_d = S_ROT;
        end else begin
          state_d = S_WALK;
        end
      end
      S_ROT: begin
        if (!ph_q) begin
          // t = 2 * (u x v), one cross term per cycle
          if (cnt_q == 5'd0) begin
            mul_a = u[nxt1(comp_q)];
            mul_b = 34'(dir_q[nxt2(comp_q)]);
            acc_d = 52'(prod);
            cnt_d = 5'd1;
          end else begin
            mul_a        = u[nxt2(comp_q)];
            mul_b        = 34'(dir_q[nxt1(comp_q)]);
            t_d[comp_q]  = 34'(acc_q - 52'(prod)) <<< 1;
            cnt_d        = 5'd0;
            if (comp_q == 2'd2) begin
              ph_d   = 1'b1;
              comp_d = 2'd0;
            end else begin
              comp_d = comp_q + 2'd1;
            end
          end
        end else begin
          // v' = v + w*t + u x t at Q42
          unique case (cnt_q)
            5'd0: begin
              mul_a = 17'(quat_q[3]);
              mul_b = t_q[comp_q];
              acc_d = (52'(dir_q[comp_q]) <<< 28) + 52'(prod);
              cnt_d = 5'd1;
            end
            5'd1: begin
              mul_a = u[nxt1(comp_q)];
              mul_b = t_q[nxt2(comp_q)];
              acc_d = acc_q + 52'(prod);
              cnt_d = 5'd2;
            end
            default: begin
              mul_a         = u[nxt2(comp_q)];
              mul_b         = t_q[nxt1(comp_q)];
              dir_d[comp_q] = round_q42(acc_q - 52'(prod));
              cnt_d         = 5'd0;
              if (comp_q == 2'd2) begin
                state_d = S_WALK;
              end else begin
                comp_d = comp_q + 2'd1;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        best_d  = 52'(thr_q) <<< 14;
        found_d = 1'b0;
        bidx_d  = '0;
        widx_d  = '0;
        lim_d   = ({25'd0, ecount_q} > 32'(MAX_ENTRIES)) ? CntW'(MAX_ENTRIES)
                                                          : CntW'(ecount_q);
        state_d = (lim_d == '0) ? S_FIN : S_RD;
      end
      S_RD: begin
        acc_d   = '0;
        comp_d  = 2'd0;
        state_d = S_DOT;
      end
      S_DOT: begin
        mul_a = 17'(dir_q[comp_q]);
        mul_b = 34'($signed(rd_q[16*comp_q +: 16]));
        sum   = acc_q + 52'(prod);
        acc_d = sum;
        if (comp_q == 2'd2) begin
          // ties go to the later entry
          if (sum >= best_q) begin
            best_d  = sum;
            bidx_d  = IdxW'(widx_q);
            found_d = 1'b1;
          end
          if (widx_q == lim_q - CntW'(1)) begin
            state_d = S_FIN;
          end else begin
            widx_d  = widx_q + CntW'(1);
            state_d = S_RD;
          end
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!outv_q || result_o.ready) begin
          outv_d           = 1'b1;
          res_d.matched    = found_q;
          res_d.best_index = found_q ? 6'(bidx_q) : 6'd0;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      comp_q   <= '0;
      ph_q     <= 1'b0;
      widx_q   <= '0;
      lim_q    <= '0;
      found_q  <= 1'b0;
      bidx_q   <= '0;
      outv_q   <= 1'b0;
      thr_q    <= 16'sd16384;
      ecount_q <= '0;
      rot_en_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      ph_q    <= ph_d;
      widx_q  <= widx_d;
      lim_q   <= lim_d;
      found_q <= found_d;
      bidx_q  <= bidx_d;
      outv_q  <= outv_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_DOT_THRESHOLD: thr_q    <= $signed(cfg_i.data);
          CFG_ENTRY_COUNT:   ecount_q <= cfg_i.data[6:0];
          CFG_ROTATE_ENABLE: rot_en_q <= cfg_i.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    kind_q <= kind_d;
    eidx_q <= eidx_d;
    rot_q  <= rot_d;
    vec_q  <= vec_d;
    quat_q <= quat_d;
    dir_q  <= dir_d;
    t_q    <= t_d;
    acc_q  <= acc_d;
    best_q <= best_d;
    v_q    <= v_d;
    r_q    <= r_d;
    b_q    <= b_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == S_NEXT && kind_q == KIND_LOAD && ({26'd0, eidx_q} < 32'(MAX_ENTRIES))) begin
      mem_q[IdxW'(eidx_q)] <= {dir_q[2], dir_q[1], dir_q[0]};
    end
    if (state_q == S_RD) begin
      rd_q <= mem_q[IdxW'(widx_q)];
    end
  end

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DOT |-> widx_q < lim_q)
    else $error("table walk beyond entries in use");

  a_unmatched_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !found_q) |-> bidx_q == '0)
    else $error("best index set without a match");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (!outv_q || result_o.ready)) |=> (outv_q && state_q == S_IDLE))
    else $error("finished query did not reach the output register");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NEXT |-> (dir_q[0] >= -16'sd16384 && dir_q[0] <= 16'sd16384 &&
                           dir_q[1] >= -16'sd16384 && dir_q[1] <= 16'sd16384 &&
                           dir_q[2] >= -16'sd16384 && dir_q[2] <= 16'sd16384))
    else $error("normalized component out of Q1.14 range");

endmodule

// ===== bench/direction_table_best_match_tb.sv =====
// Testbench for direction_table_best_match: loads random directions, queries them with and
// without inverse quaternion rotation, and checks each result against a built-in predictor.
// Depends on dtbm_pkg and the channel interfaces in dtbm_if.
`timescale 1ns / 100ps

module direction_table_best_match_tb;
  import dtbm_pkg::*;

  localparam int unsigned TableDepth = 64;
  localparam int          Q14One     = 16384;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dtbm_item_if   item_ch ();
  dtbm_result_if result_ch ();
  dtbm_cfg_if    cfg_ch ();

  direction_table_best_match #(.MAX_ENTRIES(TableDepth)) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch.sink),
    .result_o (result_ch.source),
    .cfg_i    (cfg_ch.sink)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state
  int          dir_table [TableDepth][3];
  longint      threshold_q14;
  int unsigned walk_count;
  bit          rotate_on;

  result_t     expected_results [$];
  int          send_idle_pct, recv_idle_pct;
  int          mismatch_count, query_count, load_count, result_count;

  initial begin
    item_ch.valid   = 1'b0;
    item_ch.item    = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_DOT_THRESHOLD;
    cfg_ch.data     = '0;
  end

  function automatic longint mag(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic int sat_sign(longint sign_src, longint n);
    if (n > Q14One) n = Q14One;
    return sign_src < 0 ? -int'(n) : int'(n);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic unit_vector(input longint c[3], output int u[3]);
    longint unsigned s, len, n;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(c[i] * c[i]);
    if (s == 0) begin
      u = '{0, 0, 0};
      return;
    end
    len = int_sqrt(s << 28);
    for (int i = 0; i < 3; i++) begin
      n = (longint'(mag(c[i])) * (64'd1 << 28) + (len >> 1)) / len;
      u[i] = sat_sign(c[i], n);
    end
  endtask

  function automatic int round_q42(longint a);
    return sat_sign(a, (mag(a) + (64'd1 << 27)) >> 28);
  endfunction

  task automatic conj_rotate(inout int v[3], input longint qx, qy, qz, qw);
    longint ux, uy, uz, vx, vy, vz, tx, ty, tz;
    ux = -qx; uy = -qy; uz = -qz;
    vx = v[0]; vy = v[1]; vz = v[2];
    tx = 2 * (uy * vz - uz * vy);
    ty = 2 * (uz * vx - ux * vz);
    tz = 2 * (ux * vy - uy * vx);
    v[0] = round_q42(vx * (64'sd1 << 28) + qw * tx + (uy * tz - uz * ty));
    v[1] = round_q42(vy * (64'sd1 << 28) + qw * ty + (uz * tx - ux * tz));
    v[2] = round_q42(vz * (64'sd1 << 28) + qw * tz + (ux * ty - uy * tx));
  endtask

  task automatic predict_match(input item_t it);
    longint  raw[3];
    int      dir[3];
    longint  best, d;
    int unsigned cnt;
    result_t r;
    raw[0] = it.vec_x; raw[1] = it.vec_y; raw[2] = it.vec_z;
    unit_vector(raw, dir);
    if (it.kind == KIND_LOAD) begin
      dir_table[it.entry_index] = dir;
      load_count++;
      return;
    end
    query_count++;
    if (it.use_rotation && rotate_on)
      conj_rotate(dir, it.quat_x, it.quat_y, it.quat_z, it.quat_w);
    cnt = walk_count > TableDepth ? TableDepth : walk_count;
    best = threshold_q14 * 16384;
    r = '0;
    for (int i = 0; i < cnt; i++) begin
      d = longint'(dir[0]) * dir_table[i][0] + longint'(dir[1]) * dir_table[i][1]
        + longint'(dir[2]) * dir_table[i][2];
      if (d >= best) begin
        best = d;
        r.matched = 1'b1;
        r.best_index = i[5:0];
      end
    end
    expected_results.push_back(r);
  endtask

  // Checker and random stall on the result side
  always @(posedge clk_i) begin
    result_t exp_r;
    if (result_ch.valid && result_ch.ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result matched=%0d index=%0d",
                   result_ch.result.matched, result_ch.result.best_index);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.matched !== result_ch.result.matched ||
            exp_r.best_index !== result_ch.result.best_index) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result mismatch exp matched=%0d index=%0d got matched=%0d index=%0d",
                     exp_r.matched, exp_r.best_index,
                     result_ch.result.matched, result_ch.result.best_index);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // start on the falling edge after the previous transaction dropped valid
  task automatic send_item(input item_t it);
    do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    item_ch.item  <= it;
    item_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!item_ch.ready);
    predict_match(it);
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk_i);
    // a load may still be working with no result to wait for
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_DOT_THRESHOLD: threshold_q14 = longint'($signed(val));
      CFG_ENTRY_COUNT:   walk_count = val[6:0];
      CFG_ROTATE_ENABLE: rotate_on = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_vec_comp();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(signed'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_quat_comp();
    return 16'(int'($urandom_range(2 * Q14One)) - Q14One);
  endfunction

  function automatic item_t make_item(logic kind, int idx, bit rot);
    item_t it;
    it.kind         = kind;
    it.entry_index  = idx[5:0];
    it.vec_x        = rand_vec_comp();
    it.vec_y        = rand_vec_comp();
    it.vec_z        = rand_vec_comp();
    it.use_rotation = rot;
    it.quat_x       = rand_quat_comp();
    it.quat_y       = rand_quat_comp();
    it.quat_z       = rand_quat_comp();
    it.quat_w       = rand_quat_comp();
    return it;
  endfunction

  task automatic fill_table();
    for (int i = 0; i < TableDepth; i++)
      send_item(make_item(KIND_LOAD, i, 1'($urandom_range(1))));
  endtask

  task automatic test_directed();
    item_t it;
    // zero-length load and extreme components
    it = make_item(KIND_LOAD, 0, 1'b0);
    it.vec_x = 0; it.vec_y = 0; it.vec_z = 0;
    send_item(it);
    it = make_item(KIND_LOAD, 63, 1'b1);
    it.vec_x = 16'sh8000; it.vec_y = 16'sh8000; it.vec_z = 16'sh8000;
    send_item(it);
    it = make_item(KIND_LOAD, 1, 1'b0);
    it.vec_x = 16'sh7fff; it.vec_y = 0; it.vec_z = 0;
    send_item(it);
    it = make_item(KIND_LOAD, 2, 1'b0);
    it.vec_x = 16'sh7fff; it.vec_y = 0; it.vec_z = 0;
    send_item(it);
    // query with the empty table walk (count zero) never matches
    it = make_item(KIND_QUERY, 0, 1'b0);
    it.vec_x = 1; it.vec_y = 0; it.vec_z = 0;
    send_item(it);
    drain_results();
    write_reg(CFG_ENTRY_COUNT, 16'd3);
    // identical entries 1 and 2: tie goes to the later index
    send_item(it);
    it.vec_x = 0;
    send_item(it); // zero query against threshold 1.0
    drain_results();
    write_reg(CFG_DOT_THRESHOLD, 16'(-Q14One));
    write_reg(CFG_ROTATE_ENABLE, 16'd1);
    send_item(it); // zero query, lowest threshold matches last entry
    it = make_item(KIND_QUERY, 0, 1'b1);
    it.quat_x = 16'sh4000; it.quat_y = 0; it.quat_z = 0; it.quat_w = 16'sh4000;
    send_item(it);
    it.quat_x = 16'(Q14One); it.quat_y = 16'(Q14One);
    it.quat_z = 16'(Q14One); it.quat_w = 16'(Q14One);
    send_item(it); // non-unit quaternion saturates
    it.quat_x = 16'(-Q14One); it.quat_y = 16'(-Q14One);
    it.quat_z = 16'(-Q14One); it.quat_w = 16'(-Q14One);
    it.vec_x = 16'sh8000; it.vec_y = 16'sh7fff; it.vec_z = 16'sh8000;
    send_item(it);
    drain_results();
    // count above the table depth walks only the table
    fill_table();
    drain_results();
    write_reg(CFG_ENTRY_COUNT, 16'd127);
    send_item(make_item(KIND_QUERY, 5, 1'b1));
    drain_results();
    write_reg(CFG_DOT_THRESHOLD, 16'd0);
    write_reg(CFG_DOT_THRESHOLD, 16'h7fff);
    send_item(make_item(KIND_QUERY, 5, 1'b0));
    drain_results();
  endtask

  task automatic test_random(input int n_items, input int idle_send, input int idle_recv);
    item_t it;
    send_idle_pct = idle_send;
    recv_idle_pct = idle_recv;
    drain_results();
    write_reg(CFG_DOT_THRESHOLD, 16'(int'($urandom_range(2 * Q14One)) - Q14One));
    write_reg(CFG_ENTRY_COUNT, 16'($urandom_range(1, 20)));
    write_reg(CFG_ROTATE_ENABLE, 16'($urandom_range(1)));
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(3) == 0) begin
        it = make_item(KIND_LOAD, $urandom_range(TableDepth - 1), 1'($urandom_range(1)));
      end else begin
        it = make_item(KIND_QUERY, $urandom_range(TableDepth - 1), 1'($urandom_range(1)));
        // aim some queries at a stored direction for close matches
        if ($urandom_range(1)) begin
          int e;
          e = $urandom_range(TableDepth - 1);
          it.vec_x = 16'(dir_table[e][0]);
          it.vec_y = 16'(dir_table[e][1]);
          it.vec_z = 16'(dir_table[e][2]);
        end
      end
      send_item(it);
      if (k == n_items / 2) begin
        // hold off until the block has drained, then retune
        drain_results();
        write_reg(CFG_DOT_THRESHOLD, 16'(int'($urandom_range(Q14One))));
        write_reg(CFG_ENTRY_COUNT, ($urandom_range(3) == 0) ? 16'd64 : 16'($urandom_range(1, 12)));
      end
    end
  endtask

  initial begin
    threshold_q14 = Q14One;
    walk_count = 0;
    rotate_on = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(520, 17, 78);
    test_random(520, 78, 17);
    test_random(520, 0, 0);
    drain_results();
    $display("Covered %0d loads and %0d queries, %0d results checked, %0d mismatches.",
             load_count, query_count, result_count, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #30ms;
    $display("Timeout after %0d results", result_count);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dtbm_pkg.sv
src/dtbm_if.sv
src/direction_table_best_match.sv
bench/direction_table_best_match_tb.sv
